>>> rtl/core/cfd_pkg.sv
package cfd_pkg;

  localparam int BUFFER_BYTES = 64;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
  localparam int PADDR_W = 4;

  localparam logic [FILL_W-1:0] HEADER_BYTES = FILL_W'(6);
  localparam logic [FILL_W-1:0] CRC_BYTES = FILL_W'(4);
  localparam logic [5:0] PAYLOAD_CAP = 6'd54;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic [1:0] REG_MAGIC_FIRST = 2'd0;
  localparam logic [1:0] REG_MAGIC_SECOND = 2'd1;
  localparam logic [1:0] REG_VERSION = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_HDR,
    S_CRC,
    S_CMP,
    S_SCAN,
    S_COPY,
    S_RESYNC_END,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

>>> rtl/core/cfd_byte_if.sv
interface cfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/cfd_frame_if.sv
interface cfd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_type;
  logic [5:0] payload_length;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last_of_run;

  modport source (output valid, output frame_type, output payload_length,
                  output payload_byte, output byte_valid, output last_of_run,
                  input ready);
  modport sink (input valid, input frame_type, input payload_length,
                input payload_byte, input byte_valid, input last_of_run,
                output ready);
endinterface

>>> rtl/core/cfd_ram.sv
module cfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/crc32_frame_deframer_top.sv
// channel  dir  payload                                           transfer
// rx       in   rx_byte                                           valid & ready
// tx       out  frame_type, payload_length, payload_byte,         valid & ready
//               byte_valid, last_of_run
// cfg      in   apb write of magic/version/max_payload            psel & penable & pwrite
//
// a dropped byte is taken in idle, a stored byte that needs no check passes through check;
// a byte that completes a header starts a header read, a completed frame a byte-serial crc
// through the single buffer read port, then a read and a load per payload byte emitted.
// a failed check adds a rescan and copy of up to 2 x 64 buffer reads.
// rx is ready only in idle; tx has its own output register, so a held result
// does not stop rx. reset is synchronous and clears control state only.
module crc32_frame_deframer_top import cfd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  cfd_byte_if.sink           rx,
  cfd_frame_if.source        tx,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [7:0] magic_first, magic_second, version_byte;
  logic [5:0] max_payload;

  state_t state, state_next;
  logic [FILL_W-1:0] fill, fill_next, expct, expct_next;
  logic [FILL_W-1:0] ra, ra_next, rend, rend_next, ri, ri_next, shift, shift_next;
  logic rv, rv_next, pend, pend_next;
  logic [7:0] pbyte, pbyte_next, prev, prev_next;
  logic [7:0] ver, ver_next, ftype, ftype_next, lenlo, lenlo_next;
  logic [5:0] plen, plen_next;
  logic [31:0] crc, crc_next, stored, stored_next;
  logic ovalid, ovalid_next;
  logic [7:0] obyte, obyte_next, oftype, oftype_next;
  logic [5:0] oplen, oplen_next;
  logic ovld_byte, ovld_byte_next, olast, olast_next;

  logic we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0] wdata, rdata;
  logic issue, out_free;
  logic [15:0] hdr_len;
  logic [5:0] limit;

  cfd_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first  <= 8'd170;
      magic_second <= 8'd85;
      version_byte <= 8'd1;
      max_payload  <= 6'd54;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_MAGIC_FIRST:  magic_first  <= pwdata[7:0];
        REG_MAGIC_SECOND: magic_second <= pwdata[7:0];
        REG_VERSION:      version_byte <= pwdata[7:0];
        REG_MAX_PAYLOAD:  max_payload  <= pwdata[5:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAGIC_FIRST:  prdata = {24'd0, magic_first};
      REG_MAGIC_SECOND: prdata = {24'd0, magic_second};
      REG_VERSION:      prdata = {24'd0, version_byte};
      REG_MAX_PAYLOAD:  prdata = {26'd0, max_payload};
    endcase
  end

  assign limit = (max_payload > PAYLOAD_CAP) ? PAYLOAD_CAP : max_payload;
  assign hdr_len = {rdata, lenlo};
  assign out_free = !ovalid || tx.ready;
  assign issue = ra < rend;
  assign rx.ready = (state == S_IDLE);

  assign tx.valid = ovalid;
  assign tx.frame_type = oftype;
  assign tx.payload_length = oplen;
  assign tx.payload_byte = obyte;
  assign tx.byte_valid = ovld_byte;
  assign tx.last_of_run = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      expct  <= '0;
      rv     <= 1'b0;
      pend   <= 1'b0;
      ovalid <= 1'b0;
      ra     <= '0;
      rend   <= '0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      expct  <= expct_next;
      rv     <= rv_next;
      pend   <= pend_next;
      ovalid <= ovalid_next;
      ra     <= ra_next;
      rend   <= rend_next;
    end
  end

  always_ff @(posedge clk) begin
    ri        <= ri_next;
    shift     <= shift_next;
    pbyte     <= pbyte_next;
    prev      <= prev_next;
    ver       <= ver_next;
    ftype     <= ftype_next;
    lenlo     <= lenlo_next;
    plen      <= plen_next;
    crc       <= crc_next;
    stored    <= stored_next;
    obyte     <= obyte_next;
    oftype    <= oftype_next;
    oplen     <= oplen_next;
    ovld_byte <= ovld_byte_next;
    olast     <= olast_next;
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    expct_next     = expct;
    ra_next        = ra;
    rend_next      = rend;
    rv_next        = 1'b0;
    ri_next        = ra;
    shift_next     = shift;
    pend_next      = pend;
    pbyte_next     = pbyte;
    prev_next      = prev;
    ver_next       = ver;
    ftype_next     = ftype;
    lenlo_next     = lenlo;
    plen_next      = plen;
    crc_next       = crc;
    stored_next    = stored;
    ovalid_next    = ovalid && !tx.ready;
    obyte_next     = obyte;
    oftype_next    = oftype;
    oplen_next     = oplen;
    ovld_byte_next = ovld_byte;
    olast_next     = olast;
    we             = 1'b0;
    waddr          = fill[ADDR_W-1:0];
    wdata          = rx.rx_byte;

    // shared read stream for header, crc, scan and copy
    if (state == S_HDR || state == S_CRC || state == S_SCAN || state == S_COPY) begin
      rv_next = issue;
      if (issue) begin
        ra_next = ra + 1'b1;
      end
    end

    unique case (state)
      S_IDLE: begin
        if (rx.valid) begin
          if (fill == '0 && rx.rx_byte != magic_first) begin
            fill_next = '0;
          end else if (fill == FILL_W'(1) && rx.rx_byte != magic_second) begin
            fill_next = (rx.rx_byte == magic_first) ? FILL_W'(1) : '0;
          end else if (fill == FILL_W'(BUFFER_BYTES)) begin
            pend_next  = 1'b1;
            pbyte_next = rx.rx_byte;
            ra_next    = '0;
            rend_next  = fill;
            state_next = S_SCAN;
          end else begin
            we         = 1'b1;
            fill_next  = fill + 1'b1;
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (expct == '0) begin
          if (fill < HEADER_BYTES) begin
            state_next = S_IDLE;
          end else begin
            ra_next    = FILL_W'(2);
            rend_next  = HEADER_BYTES;
            state_next = S_HDR;
          end
        end else if (fill < expct) begin
          state_next = S_IDLE;
        end else begin
          ra_next    = '0;
          rend_next  = expct;
          crc_next   = CRC_INIT;
          state_next = S_CRC;
        end
      end
      S_HDR: begin
        if (rv) begin
          unique case (ri[2:0])
            3'd2:    ver_next = rdata;
            3'd3:    ftype_next = rdata;
            3'd4:    lenlo_next = rdata;
            default: begin
              if (ver != version_byte || hdr_len > {10'd0, limit}) begin
                // bad header: rescan for a later magic pair
                if (fill == '0) begin
                  state_next = S_RESYNC_END;
                end else begin
                  ra_next    = '0;
                  rend_next  = fill;
                  state_next = S_SCAN;
                end
                rv_next = 1'b0;
              end else begin
                expct_next = HEADER_BYTES + CRC_BYTES + FILL_W'(hdr_len[5:0]);
                plen_next  = hdr_len[5:0];
                state_next = S_CHECK;
              end
            end
          endcase
        end
      end
      S_CRC: begin
        if (rv) begin
          if (ri < expct - CRC_BYTES) begin
            crc_next = crc_byte(crc, rdata);
          end else begin
            stored_next = {rdata, stored[31:8]};
          end
          if (ri == expct - 1'b1) begin
            state_next = S_CMP;
          end
        end
      end
      S_CMP: begin
        if ((crc ^ CRC_INIT) == stored) begin
          ra_next    = HEADER_BYTES;
          state_next = S_EMIT_RD;
        end else begin
          ra_next    = '0;
          rend_next  = fill;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rv) begin
          prev_next = rdata;
          if (ri >= FILL_W'(2) && prev == magic_first && rdata == magic_second) begin
            shift_next = ri - 1'b1;
            ra_next    = ri - 1'b1;
            rend_next  = fill;
            rv_next    = 1'b0;
            state_next = S_COPY;
          end else if (ri == fill - 1'b1) begin
            // no pair: keep a trailing first sync byte alone
            if (rdata == magic_first) begin
              we        = 1'b1;
              waddr     = '0;
              wdata     = magic_first;
              fill_next = FILL_W'(1);
            end else begin
              fill_next = '0;
            end
            expct_next = '0;
            rv_next    = 1'b0;
            state_next = S_RESYNC_END;
          end
        end
      end
      S_COPY: begin
        if (rv) begin
          we    = 1'b1;
          waddr = ADDR_W'(ri - shift);
          wdata = rdata;
          if (ri == fill - 1'b1) begin
            fill_next  = fill - shift;
            expct_next = '0;
            rv_next    = 1'b0;
            state_next = S_RESYNC_END;
          end
        end
      end
      S_RESYNC_END: begin
        expct_next = '0;
        if (pend) begin
          we        = 1'b1;
          wdata     = pbyte;
          fill_next = fill + 1'b1;
          pend_next = 1'b0;
        end
        state_next = S_CHECK;
      end
      S_EMIT_RD: begin
        if (plen == '0) begin
          if (out_free) begin
            ovalid_next    = 1'b1;
            obyte_next     = '0;
            oftype_next    = ftype;
            oplen_next     = plen;
            ovld_byte_next = 1'b0;
            olast_next     = 1'b1;
            fill_next      = '0;
            expct_next     = '0;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        if (out_free) begin
          ovalid_next    = 1'b1;
          obyte_next     = rdata;
          oftype_next    = ftype;
          oplen_next     = plen;
          ovld_byte_next = 1'b1;
          olast_next     = (ra == HEADER_BYTES + FILL_W'(plen) - 1'b1);
          if (ra == HEADER_BYTES + FILL_W'(plen) - 1'b1) begin
            fill_next  = '0;
            expct_next = '0;
            state_next = S_IDLE;
          end else begin
            ra_next    = ra + 1'b1;
            state_next = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
